// ===== rtl/flur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flur_pkg
// Widths, stage sizing and the pipeline word type for the four-lane
// unsigned remainder block.
// ----------------------------------------------------------------------------
package flur_pkg;

   localparam int DIVIDEND_BITS  = 28;
   localparam int DIVISOR_BITS   = 28;
   localparam int REM_BITS       = 27;
   localparam int LANES          = 4;
   localparam int BITS_PER_STAGE = 4;
   localparam int STAGES         = (DIVIDEND_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

   localparam logic [DIVISOR_BITS-1:0] REM_MAX = DIVISOR_BITS'(32'h07FF_FFFF);

   // One word as it moves down the divider pipeline
   typedef struct packed {
      logic                                     valid;
      logic [DIVISOR_BITS-1:0]                  divisor;
      logic [LANES-1:0][DIVISOR_BITS-1:0]       rem;
      logic [LANES-1:0][DIVIDEND_BITS-1:0]      dividend;
   } stage_type;

endpackage

// ===== rtl/flur_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flur_req_if / flur_rsp_if
// Valid/ready channels carrying the operand word and the remainder word.
// ----------------------------------------------------------------------------
interface flur_req_if import flur_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [DIVIDEND_BITS-1:0] dividend_0;
   logic [DIVIDEND_BITS-1:0] dividend_1;
   logic [DIVIDEND_BITS-1:0] dividend_2;
   logic [DIVIDEND_BITS-1:0] dividend_3;
   logic [DIVISOR_BITS-1:0]  divisor;

   modport source (output valid, dividend_0, dividend_1, dividend_2, dividend_3, divisor,
                   input ready);
   modport sink   (input valid, dividend_0, dividend_1, dividend_2, dividend_3, divisor,
                   output ready);
endinterface

interface flur_rsp_if import flur_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REM_BITS-1:0] remainder_0;
   logic [REM_BITS-1:0] remainder_1;
   logic [REM_BITS-1:0] remainder_2;
   logic [REM_BITS-1:0] remainder_3;

   modport source (output valid, remainder_0, remainder_1, remainder_2, remainder_3,
                   input ready);
   modport sink   (input valid, remainder_0, remainder_1, remainder_2, remainder_3,
                   output ready);
endinterface

// ===== rtl/flur_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flur_stage
// One pipeline stage: BITS_PER_STAGE restoring-division steps on every lane.
// ----------------------------------------------------------------------------
module flur_stage import flur_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage_in,
   output stage_type stage_ff
);

   stage_type stage_in_next;

   // Shift in one dividend bit per step, subtract the divisor where it fits
   always_comb begin
      logic [DIVISOR_BITS:0] trial;
      stage_in_next = stage_in;
      for (int k = 0; k < LANES; k++) begin
         for (int s = 0; s < BITS_PER_STAGE; s++) begin
            trial = {stage_in_next.rem[k], stage_in_next.dividend[k][DIVIDEND_BITS-1]};
            if (trial >= {1'b0, stage_in.divisor}) begin
               trial = trial - {1'b0, stage_in.divisor};
            end
            stage_in_next.rem[k]      = trial[DIVISOR_BITS-1:0];
            stage_in_next.dividend[k] = {stage_in_next.dividend[k][DIVIDEND_BITS-2:0], 1'b0};
         end
      end
   end

   // Advance the word when the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_next.valid;
      end
      if (advance) begin
         stage_ff.divisor  <= stage_in_next.divisor;
         stage_ff.rem      <= stage_in_next.rem;
         stage_ff.dividend <= stage_in_next.dividend;
      end
   end

endmodule

// ===== rtl/four_lane_unsigned_remainder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_lane_unsigned_remainder
// Unsigned remainder of four 28-bit dividends by one shared divisor.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operand word: four dividends and a shared divisor.
//   rsp_ch returns one word per request: the four remainders, in order.
//   The divider is a restoring array cut into STAGES (7) register stages of
//   four division steps each. An accepted request moves through the stages in
//   order and shows valid on rsp_ch once it reaches the last one. One word
//   enters per cycle while the receiver takes words, so throughput is one
//   word per cycle.
//   A zero divisor returns the dividend; any remainder above 27 bits
//   saturates to all ones.
//   A finished word waiting unclaimed on rsp_ch holds the whole pipeline,
//   bubbles included, and drops req_ch.ready until it is taken; with the
//   last stage empty everything moves whatever rsp_ch.ready says.
//   Synchronous reset clears every stage valid bit; nothing else is kept.
// ----------------------------------------------------------------------------
module four_lane_unsigned_remainder import flur_pkg::*; (
   input logic         clock,
   input logic         reset,
   flur_req_if.sink    req_ch,
   flur_rsp_if.source  rsp_ch
);

   stage_type                 stage_word [STAGES+1];
   stage_type                 last_word;
   logic                      advance;
   logic [LANES-1:0][REM_BITS-1:0] rem_sat;

   // Move everything unless a finished word is waiting
   assign advance      = !last_word.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Build the input word
   always_comb begin
      stage_word[0].valid       = req_ch.valid;
      stage_word[0].divisor     = req_ch.divisor;
      stage_word[0].rem         = '0;
      stage_word[0].dividend[0] = req_ch.dividend_0;
      stage_word[0].dividend[1] = req_ch.dividend_1;
      stage_word[0].dividend[2] = req_ch.dividend_2;
      stage_word[0].dividend[3] = req_ch.dividend_3;
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      flur_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage_in (stage_word[g]),
         .stage_ff (stage_word[g+1])
      );
   end

   assign last_word = stage_word[STAGES];

   // Clamp remainders to the output width
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (last_word.rem[k] > REM_MAX) begin
            rem_sat[k] = REM_MAX[REM_BITS-1:0];
         end else begin
            rem_sat[k] = last_word.rem[k][REM_BITS-1:0];
         end
      end
   end

   assign rsp_ch.valid       = last_word.valid;
   assign rsp_ch.remainder_0 = rem_sat[0];
   assign rsp_ch.remainder_1 = rem_sat[1];
   assign rsp_ch.remainder_2 = rem_sat[2];
   assign rsp_ch.remainder_3 = rem_sat[3];

   // Checks
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (last_word.valid && last_word.divisor != '0) |->
         (last_word.rem[0] < last_word.divisor && last_word.rem[1] < last_word.divisor &&
          last_word.rem[2] < last_word.divisor && last_word.rem[3] < last_word.divisor))
      else $error("remainder not below divisor");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while output stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("output valid right after reset");

endmodule

// ===== dv/remainder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remainder_checker
// Watches the operand and remainder channels, computes the expected four
// remainders for every accepted operand word and compares them in order.
// ----------------------------------------------------------------------------
module remainder_checker import flur_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   flur_req_if.sink    req_mon,
   flur_rsp_if.sink    rsp_mon,
   output int          mismatch_count,
   output int          pending_count,
   output int          words_checked
);

   typedef logic [LANES-1:0][REM_BITS-1:0] rem_word_type;

   rem_word_type expected_rems[$];

   // Exact remainder; zero divisor leaves the dividend; saturate to 27 bits
   function automatic logic [REM_BITS-1:0] lane_mod(logic [DIVIDEND_BITS-1:0] num,
                                                    logic [DIVISOR_BITS-1:0] den);
      logic [DIVIDEND_BITS-1:0] r;
      r = (den == '0) ? num : (num % den);
      if (r > DIVIDEND_BITS'(32'h07FF_FFFF))
         r = DIVIDEND_BITS'(32'h07FF_FFFF);
      return r[REM_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   assign pending_count = expected_rems.size();

   initial begin
      mismatch_count = 0;
      words_checked  = 0;
   end

   always @(posedge clock) begin
      rem_word_type want;
      rem_word_type got;
      if (!reset) begin
         // predict on operand acceptance
         if (req_mon.valid && req_mon.ready) begin
            want[0] = lane_mod(req_mon.dividend_0, req_mon.divisor);
            want[1] = lane_mod(req_mon.dividend_1, req_mon.divisor);
            want[2] = lane_mod(req_mon.dividend_2, req_mon.divisor);
            want[3] = lane_mod(req_mon.dividend_3, req_mon.divisor);
            expected_rems.push_back(want);
         end
         // compare on result acceptance
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.remainder_3, rsp_mon.remainder_2,
                   rsp_mon.remainder_1, rsp_mon.remainder_0};
            if (expected_rems.size() == 0) begin
               report_mismatch("unexpected word", 32'(got[0]), 0);
            end else begin
               want = expected_rems.pop_front();
               words_checked++;
               for (int k = 0; k < LANES; k++)
                  if (got[k] !== want[k])
                     report_mismatch($sformatf("remainder_%0d", k), 32'(got[k]),
                                     32'(want[k]));
            end
         end
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operand words into the four-lane remainder block with random
// idling on both sides and one long output hold-off; a checker compares.
// ----------------------------------------------------------------------------
module testbench import flur_pkg::*;;

   localparam int RANDOM_WORDS  = 1100;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int LATENCY       = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   flur_req_if req_ch();
   flur_rsp_if rsp_ch();

   int mismatch_count, pending_count, words_checked;
   int idle_cycles = 0;
   int zero_divisor_words = 0;
   bit quiet_phase = 1'b0;
   bit hold_off = 1'b0;

   four_lane_unsigned_remainder uut (
      .clock (clock), .reset (reset), .req_ch (req_ch.sink), .rsp_ch (rsp_ch.source)
   );

   remainder_checker checker_inst (
      .clock (clock), .reset (reset), .req_mon (req_ch.sink), .rsp_mon (rsp_ch.sink),
      .mismatch_count (mismatch_count), .pending_count (pending_count),
      .words_checked (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.dividend_0 = '0;
      req_ch.dividend_1 = '0;
      req_ch.dividend_2 = '0;
      req_ch.dividend_3 = '0;
      req_ch.divisor = '0;
      rsp_ch.ready = 1'b0;
   end

   // Pick a dividend, often near the edges
   function automatic logic [DIVIDEND_BITS-1:0] pick_dividend();
      case ($urandom_range(0, 4))
         0: pick_dividend = DIVIDEND_BITS'($urandom_range(0, 15));
         1: pick_dividend = '1 - DIVIDEND_BITS'($urandom_range(0, 15));
         default: pick_dividend = DIVIDEND_BITS'($urandom);
      endcase
   endfunction

   // Pick a divisor; mostly legal, sometimes zero or above 2^27
   function automatic logic [DIVISOR_BITS-1:0] pick_divisor();
      case ($urandom_range(0, 9))
         0: pick_divisor = DIVISOR_BITS'($urandom_range(1, 16));
         1: pick_divisor = DIVISOR_BITS'(1) << $urandom_range(0, 27);
         2: pick_divisor = DIVISOR_BITS'($urandom_range(0, 1) ? 0 : $urandom);
         3: pick_divisor = DIVISOR_BITS'($urandom_range(1, 255)) << $urandom_range(0, 20);
         default: pick_divisor = DIVISOR_BITS'($urandom_range(1, 134217728));
      endcase
   endfunction

   // Offer one word and hold it until accepted, with optional idle burst first
   task automatic send_word(input logic [DIVIDEND_BITS-1:0] d0, d1, d2, d3,
                            input logic [DIVISOR_BITS-1:0] den);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.dividend_0 <= d0;
      req_ch.dividend_1 <= d1;
      req_ch.dividend_2 <= d2;
      req_ch.dividend_3 <= d3;
      req_ch.divisor    <= den;
      if (den == '0) zero_divisor_words++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Result side: random stall bursts, one long hold-off, none at the end
   initial begin
      int burst;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog expired with %0d words outstanding", pending_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [DIVIDEND_BITS-1:0] top_val;
      int settle;
      top_val = '1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero divisor, oversized divisor, exact multiples
      send_word('0, 1, top_val, top_val - 1, 1);
      send_word('0, 1, top_val, 28'h7FF_FFFF, 28'h800_0000);
      send_word('0, 1, top_val, 28'h800_0000, 28'hFFF_FFFF);
      send_word('0, 28'h7FF_FFFF, top_val, 28'h800_0000, '0);
      send_word(28'hAAA_AAAA, 28'h555_5555, 12, 13, 3);
      send_word(28'h555_5555, 28'hAAA_AAAA, 28'h800_0001, 6, 28'h7FF_FFFF);
      send_word(100, 99, 101, 0, 100);
      send_word(top_val, top_val, top_val, top_val, 28'h400_0000);
      send_word(28'h123_4567, 28'h89A_BCDE, 28'hF0F_0F0F, 28'h0F0_F0F0, 28'h00F_FFFF);
      send_word(7, 8, 9, 10, 28'h900_0000);

      // random part; long output hold-off somewhere in the middle
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 400) hold_off = 1'b1;
         if (n == RANDOM_WORDS - 150) quiet_phase = 1'b1;
         send_word(pick_dividend(), pick_dividend(), pick_dividend(), pick_dividend(),
                   pick_divisor());
      end
      req_ch.valid <= 1'b0;

      settle = 0;
      while (pending_count != 0 && settle < WATCHDOG_MAX) begin
         @(posedge clock);
         settle++;
      end
      repeat (LATENCY + 3) @(posedge clock);

      $display("checked %0d remainder words, %0d of them with a zero divisor",
               words_checked, zero_divisor_words);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/flur_pkg.sv
rtl/flur_if.sv
rtl/flur_stage.sv
rtl/four_lane_unsigned_remainder.sv
dv/remainder_checker.sv
dv/testbench.sv
